// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and field widths shared by the sorted priority queue cells
// and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int KEY_W  = 7;
	localparam int TAG_W  = 16;
	localparam int CODE_W = 2;
	localparam int BILL_W = 16;
	localparam int OCC_W  = 7;

	localparam int ENTRY_W = KEY_W + TAG_W + CODE_W + BILL_W;
	// request data: entry packed from bit 0, padded to whole bytes
	localparam int S_DATA_W = ((ENTRY_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((ENTRY_W + OCC_W + 7) / 8) * 8;

	localparam int CAPACITY_DEF = 64;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_SERVED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// field order matches tdata, lowest bits last in the struct
	typedef struct packed {
		logic [BILL_W-1:0] bill;
		logic [CODE_W-1:0] code;
		logic [TAG_W-1:0]  tag;
		logic [KEY_W-1:0]  key;
	} entry_t;

	typedef struct packed {
		logic ins;   // insert the new entry this cycle
		logic deq;   // shift everything one cell toward the head
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue. Keeps its entry, takes the new entry, or
// takes its left neighbor's entry on insert; takes the right neighbor's on
// dequeue.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire entry_t    new_entry,
	input  wire logic      occupied,
	input  wire logic      left_ge,
	input  wire entry_t    left_entry,
	input  wire entry_t    right_entry,
	output logic           ge,
	output entry_t         entry_q
);

	// stays ahead of the new entry: occupied and key not below it (FIFO on ties)
	assign ge = occupied && (entry_q.key >= new_entry.key);

	always_ff @(posedge clk) begin
		if (ctl.deq) begin
			entry_q <= right_entry;
		end else if (ctl.ins && !ge) begin
			if (left_ge) begin
				entry_q <= new_entry;
			end else begin
				entry_q <= left_entry;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/stable_max_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_max_priority_queue
// Bounded priority queue, highest key at the head, first in first out among
// equal keys. Built as a row of cells that all compare against the new key
// and shift in the same cycle.
//
//   channel  | dir | tdata (low bit up)                        | tuser
//   ---------+-----+-------------------------------------------+-------------
//   s_*      | in  | age_key, customer_tag, order_code,        | command
//            |     | bill_amount, zero pad                     |
//   m_*      | out | out_age_key, out_customer_tag,            | status
//            |     | out_order_code, out_bill_amount, occupancy|
//
// One request per cycle while the output register keeps draining: every cell
// compares its key with the new key in parallel and moves at most one place.
// The response sits in an output register; a new request is taken whenever
// that register is empty or being read in the same cycle.
// Reset clears the entry count and the output valid; cell contents are left.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_max_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // age_key, customer_tag, order_code, bill_amount
	input  wire logic [0:0]          s_tuser,  // command
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,  // out_age_key, out_customer_tag,
	                                           // out_order_code, out_bill_amount, occupancy
	output logic [1:0]               m_tuser   // status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	status_t          out_status_q;
	entry_t           out_entry_q;
	logic [OCC_W-1:0] out_occ_q;

	logic             accept;
	cmd_t             cmd;
	entry_t           new_entry;
	logic             full;
	logic             empty;
	cell_ctl_t        ctl;
	logic [CNT_W-1:0] count_d;
	status_t          status_d;
	entry_t           resp_entry_d;

	entry_t           cell_q  [CAPACITY];
	logic             cell_ge [CAPACITY];

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cmd       = cmd_t'(s_tuser[0]);
	assign new_entry = entry_t'(s_tdata[ENTRY_W-1:0]);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);

	assign ctl.ins = accept && (cmd == CMD_ENQ) && !full;
	assign ctl.deq = accept && (cmd == CMD_DEQ) && !empty;

	always_comb begin
		count_d      = count_q;
		status_d     = ST_ENQUEUED;
		resp_entry_d = '0;
		unique case (cmd)
			CMD_ENQ: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_DEQ: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					status_d     = ST_SERVED;
					resp_entry_d = cell_q[0];
					count_d      = count_q - CNT_W'(1);
				end
			end
			default: status_d = ST_ENQUEUED;
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   occ;
		logic   lge;
		entry_t lent;
		entry_t rent;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign lge  = 1'b1;
			assign lent = new_entry;
		end else begin : g_body
			assign lge  = cell_ge[i-1];
			assign lent = cell_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rent = '0;
		end else begin : g_mid
			assign rent = cell_q[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.occupied   (occ),
			.left_ge    (lge),
			.left_entry (lent),
			.right_entry(rent),
			.ge         (cell_ge[i]),
			.entry_q    (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status_d;
			out_entry_q  <= resp_entry_d;
			out_occ_q    <= OCC_W'(count_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = M_DATA_W'({out_occ_q, out_entry_q});

	// ---------------- assertions ----------------

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not bump count");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_DEQ) && empty |=> m_tvalid && (m_tuser == ST_EMPTY))
		else $error("dequeue on empty not reported");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (cell_q[0].key >= cell_q[1].key))
		else $error("head out of order");

endmodule

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: stable_max_priority_queue
// Drives enqueue and dequeue requests on the input stream. A shadow queue,
// kept sorted by key with FIFO order among equal keys, predicts every
// response. Responses are compared field by field in order. Random gaps
// fall on both streams, and one long output stall fills the pipe.
// ----------------------------------------------------------------------------
module tb;
	import spq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PAD_W       = S_DATA_W - ENTRY_W;

	typedef struct {
		status_t          status;
		entry_t           served;
		logic [OCC_W-1:0] occupancy;
	} reply_t;

	class queue_tracker;
		entry_t      held[$];
		reply_t      pending_replies[$];
		int unsigned faults;
		int unsigned tally[4];
		int unsigned peak;

		function void note_request(cmd_t cmd, entry_t item);
			reply_t r;
			int     pos;
			r.served = '0;
			if (cmd == CMD_ENQ) begin
				if (held.size() >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// new entry goes behind every entry with key >= its own
					pos = 0;
					while (pos < held.size() && held[pos].key >= item.key)
						pos++;
					held.insert(pos, item);
					r.status = ST_ENQUEUED;
				end
			end else if (held.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.served = held.pop_front();
				r.status = ST_SERVED;
			end
			r.occupancy = OCC_W'(held.size());
			if (held.size() > peak)
				peak = held.size();
			tally[r.status]++;
			pending_replies.push_back(r);
		endfunction

		function void check_response(logic [1:0] status, entry_t got,
				logic [OCC_W-1:0] occ);
			reply_t want;
			if (pending_replies.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%t: response with no request pending: status %0d", $realtime,
						status);
				return;
			end
			want = pending_replies.pop_front();
			if (status !== want.status || got.key !== want.served.key
					|| got.tag !== want.served.tag || got.code !== want.served.code
					|| got.bill !== want.served.bill || occ !== want.occupancy) begin
				faults++;
				if (faults <= 10) begin
					$display("%t: expected status %0d key %0d tag %h code %0d bill %h occ %0d",
						$realtime, want.status, want.served.key, want.served.tag,
						want.served.code, want.served.bill, want.occupancy);
					$display("%t:   actual status %0d key %0d tag %h code %0d bill %h occ %0d",
						$realtime, status, got.key, got.tag, got.code, got.bill, occ);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [0:0]          s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [1:0]          m_tuser;

	queue_tracker tracker = new();
	bit           long_stall_due = 0;
	bit           steady = 0;
	int unsigned  cycle_count = 0;

	stable_max_priority_queue #(.CAPACITY(QUEUE_DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// note the request before checking, so a same-edge response still finds it
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			tracker.note_request(cmd_t'(s_tuser[0]), entry_t'(s_tdata[ENTRY_W-1:0]));
		if (arst_n && m_tvalid && m_tready)
			tracker.check_response(m_tuser, entry_t'(m_tdata[ENTRY_W-1:0]),
				m_tdata[ENTRY_W +: OCC_W]);
	end

	// output side: one m_tready assignment per decision, held until the next decision
	initial begin
		int r;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (long_stall_due) begin
				long_stall_due = 0;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (r < 10) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(8, 40)) @(posedge clk);
			end else if (r < 40) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else if (r < 55) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(50, 150)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(cmd_t cmd, entry_t item, logic [PAD_W-1:0] pad);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {pad, item};
		do @(posedge clk); while (!s_tready);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic enqueue(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
			logic [CODE_W-1:0] code, logic [BILL_W-1:0] bill);
		entry_t e;
		e.key  = key;
		e.tag  = tag;
		e.code = code;
		e.bill = bill;
		send_request(CMD_ENQ, e, '0);
	endtask

	task automatic dequeue();
		send_request(CMD_DEQ, '0, '0);
	endtask

	initial begin
		entry_t e;
		int     fill_bias;
		int     key_mode;
		int     burst_len;
		cmd_t   cmd;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty dequeue, field extremes, ties at head, middle and tail
		dequeue();
		enqueue(7'd0, 16'h0000, 2'd0, 16'h0000);
		enqueue(7'd127, 16'hffff, 2'd3, 16'hffff);
		enqueue(7'd127, 16'h0001, 2'd1, 16'h0001);  // ties with head, goes behind it
		enqueue(7'd64, 16'h5a5a, 2'd2, 16'ha5a5);
		enqueue(7'd64, 16'h1234, 2'd1, 16'h4321);
		enqueue(7'd0, 16'hbeef, 2'd3, 16'h00ff);    // ties with tail
		e = '{bill: 16'h8001, code: 2'd2, tag: 16'h7ffe, key: 7'd65};
		send_request(CMD_ENQ, e, '1);               // pad bits set, must be ignored
		repeat (8) dequeue();                       // drains, then reports empty
		e = '{bill: 16'hffff, code: 2'd3, tag: 16'hffff, key: 7'd127};
		send_request(CMD_DEQ, e, '1);               // payload on a dequeue is ignored

		// random bursts: fill bursts run into full, drain bursts into empty
		for (int b = 0; b < 10; b++) begin
			fill_bias = (b >= 8) ? 50 : ((b % 2 == 0) ? 85 : 15);
			key_mode  = $urandom_range(0, 2);
			steady    = ($urandom_range(0, 3) == 0);
			burst_len = $urandom_range(80, 130);
			if (b == 2)
				long_stall_due = 1;
			for (int i = 0; i < burst_len; i++) begin
				cmd = ($urandom_range(0, 99) < fill_bias) ? CMD_ENQ : CMD_DEQ;
				e.tag  = TAG_W'($urandom);
				e.code = CODE_W'($urandom);
				e.bill = BILL_W'($urandom);
				case (key_mode)
					0: e.key = KEY_W'($urandom);
					1: e.key = KEY_W'($urandom_range(0, 3));
					default: e.key = KEY_W'($urandom_range(124, 127));
				endcase
				send_request(cmd, e, PAD_W'($urandom));
			end
		end
		steady = 0;
		s_tvalid <= 1'b0;

		while (tracker.pending_replies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d enqueued, %0d served, %0d empty, %0d full responses",
			tracker.tally[ST_ENQUEUED], tracker.tally[ST_SERVED],
			tracker.tally[ST_EMPTY], tracker.tally[ST_FULL]);
		$display("queue depth reached %0d of %0d; %0d mismatches", tracker.peak,
			QUEUE_DEPTH, tracker.faults);
		if (tracker.faults == 0 && tracker.pending_replies.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
